// ===== hdl/ufaf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ufaf_pkg;

   // whitelist register slots present in the register map
   localparam int SLOT_CAP = 3;
   localparam logic [1:0] NO_SLOT = 2'd3;

   // frame byte counter saturates here
   localparam logic [9:0] COUNT_LIMIT = 10'h3FF;
   localparam int MIN_FRAME_BYTES = 8;

   // crc16-ccitt
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_MSB  = 16'h8000;

   localparam logic [15:0] RATE_COUNT_MAX = 16'hFFFF;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // verdict codes
   localparam logic [3:0] VERDICT_PASS         = 4'd0;
   localparam logic [3:0] VERDICT_SIZE         = 4'd1;
   localparam logic [3:0] VERDICT_MAGIC        = 4'd2;
   localparam logic [3:0] VERDICT_UNKNOWN_RATE = 4'd3;
   localparam logic [3:0] VERDICT_UNKNOWN_SRC  = 4'd4;
   localparam logic [3:0] VERDICT_KNOWN_RATE   = 4'd5;
   localparam logic [3:0] VERDICT_PAYLOAD_LONG = 4'd6;
   localparam logic [3:0] VERDICT_TRUNCATED    = 4'd7;
   localparam logic [3:0] VERDICT_CRC          = 4'd8;

   // register indexes
   localparam logic [3:0] CSR_MAGIC_WORD     = 4'd0;
   localparam logic [3:0] CSR_WHITELIST_IP_A = 4'd1;
   localparam logic [3:0] CSR_WHITELIST_IP_B = 4'd2;
   localparam logic [3:0] CSR_WHITELIST_IP_C = 4'd3;
   localparam logic [3:0] CSR_ACTIVE_SLOTS   = 4'd4;
   localparam logic [3:0] CSR_RATE_WINDOW    = 4'd5;
   localparam logic [3:0] CSR_MAX_KNOWN      = 4'd6;
   localparam logic [3:0] CSR_MAX_UNKNOWN    = 4'd7;

   typedef struct packed {
      logic [15:0]                 magic_word;
      logic [SLOT_CAP-1:0][31:0]   whitelist_ip;
      logic [1:0]                  active_slots;
      logic [15:0]                 window_len_ms;
      logic [15:0]                 max_known_per_window;
      logic [15:0]                 max_unknown_per_window;
   } cfg_type;

   // per-frame summary handed from front to back
   typedef struct packed {
      logic        size_bad;
      logic        magic_bad;
      logic [1:0]  slot;
      logic        payload_long;
      logic        truncated;
      logic        crc_bad;
      logic [15:0] payload_length;
      logic [31:0] now_ms;
   } frame_sum_type;

   typedef struct packed {
      logic [15:0] count;
      logic        restart;
   } rate_type;

   // one byte of crc16-ccitt, msb first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_MSB) != 16'h0000) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

   // window restart on expiry, then saturating count of one packet
   function automatic rate_type count_packet(input logic [15:0] count,
                                             input logic [31:0] win_begin,
                                             input logic [31:0] now,
                                             input logic [15:0] window);
      rate_type    r;
      logic [31:0] age;
      logic [15:0] base;
      age       = now - win_begin;
      r.restart = age > {16'h0000, window};
      base      = r.restart ? 16'h0000 : count;
      r.count   = (base != RATE_COUNT_MAX) ? base + 16'd1 : base;
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/ufaf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ufaf_front
   import ufaf_pkg::*;
#(
   parameter int WHITELIST_SLOTS   = 3,
   parameter int MAX_FRAME_BYTES   = 512,
   parameter int MAX_PAYLOAD_BYTES = 400
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cfg_type       cfg,
   input  wire logic          byte_accept,
   input  wire logic [7:0]    data_byte,
   input  wire logic          first_byte,
   input  wire logic          last_byte,
   input  wire logic [31:0]   source_ip,
   input  wire logic [31:0]   now_ms,
   output logic               sum_valid,
   output frame_sum_type      sum
);

   logic [9:0]  byte_count_ff, byte_count_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] frozen_ff, frozen_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] trailer_ff, trailer_in;
   logic        magic_ff, magic_in;

   logic [9:0]  idx;
   logic [15:0] crc_cur, frozen_cur, length_cur, trailer_cur;
   logic        magic_cur;
   logic [16:0] pos, end_pos;
   logic [10:0] frame_len;
   logic [1:0]  nslots;
   logic [1:0]  slot_hit;

   // frame state as seen by this byte: a first mark starts from clear state
   always_comb begin
      idx         = first_byte ? 10'd0 : byte_count_ff;
      crc_cur     = first_byte ? CRC_INIT : crc_ff;
      frozen_cur  = first_byte ? 16'h0000 : frozen_ff;
      length_cur  = first_byte ? 16'h0000 : length_ff;
      trailer_cur = first_byte ? 16'h0000 : trailer_ff;
      magic_cur   = first_byte ? 1'b0 : magic_ff;
   end

   // field capture and crc update for the byte at position idx
   always_comb begin
      byte_count_in = idx;
      crc_in        = crc_cur;
      frozen_in     = frozen_cur;
      length_in     = length_cur;
      trailer_in    = trailer_cur;
      magic_in      = magic_cur;
      pos           = {7'd0, idx};
      end_pos       = 17'd5 + {1'b0, length_cur};
      if (idx != COUNT_LIMIT) begin
         if (idx == 10'd0) begin
            magic_in = data_byte == cfg.magic_word[7:0];
         end else if (idx == 10'd1) begin
            magic_in = magic_cur && (data_byte == cfg.magic_word[15:8]);
         end
         if (idx == 10'd4) begin
            length_in = {length_cur[15:8], data_byte};
         end else if (idx == 10'd5) begin
            length_in = {data_byte, length_cur[7:0]};
         end
         end_pos = 17'd5 + {1'b0, length_in};
         if (pos >= 17'd2 && pos <= end_pos) begin
            crc_in = crc_byte(crc_cur, data_byte);
            if (pos == end_pos) begin
               frozen_in = crc_in;
            end
         end else if (pos == end_pos + 17'd1) begin
            trailer_in = {trailer_cur[15:8], data_byte};
         end else if (pos == end_pos + 17'd2) begin
            trailer_in = {data_byte, trailer_cur[7:0]};
         end
         byte_count_in = idx + 10'd1;
      end
   end

   // whitelist match, first active slot wins
   always_comb begin
      nslots   = (cfg.active_slots < 2'(WHITELIST_SLOTS)) ? cfg.active_slots
                                                          : 2'(WHITELIST_SLOTS);
      slot_hit = NO_SLOT;
      for (int i = WHITELIST_SLOTS - 1; i >= 0; i--) begin
         if (2'(i) < nslots && cfg.whitelist_ip[i] == source_ip) begin
            slot_hit = 2'(i);
         end
      end
   end

   // frame summary on the last byte
   always_comb begin
      frame_len          = {1'b0, idx} + 11'd1;
      sum_valid          = byte_accept && last_byte;
      sum.size_bad       = frame_len < 11'(MIN_FRAME_BYTES) ||
                           frame_len > 11'(MAX_FRAME_BYTES);
      sum.magic_bad      = !magic_in;
      sum.slot           = slot_hit;
      sum.payload_long   = length_in > 16'(MAX_PAYLOAD_BYTES);
      sum.truncated      = {6'd0, frame_len} < 17'(MIN_FRAME_BYTES) + {1'b0, length_in};
      sum.crc_bad        = trailer_in != frozen_in;
      sum.payload_length = length_in;
      sum.now_ms         = now_ms;
   end

   // frame state registers, cleared after each frame's last byte
   always_ff @(posedge clock) begin
      if (reset || (byte_accept && last_byte)) begin
         byte_count_ff <= 10'd0;
         crc_ff        <= CRC_INIT;
         frozen_ff     <= 16'h0000;
         length_ff     <= 16'h0000;
         trailer_ff    <= 16'h0000;
         magic_ff      <= 1'b0;
      end else if (byte_accept) begin
         byte_count_ff <= byte_count_in;
         crc_ff        <= crc_in;
         frozen_ff     <= frozen_in;
         length_ff     <= length_in;
         trailer_ff    <= trailer_in;
         magic_ff      <= magic_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/ufaf_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ufaf_queue
   import ufaf_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire frame_sum_type push_data,
   output logic               full,
   input  wire logic          pop,
   output frame_sum_type      pop_data,
   output logic               empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   frame_sum_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]        count_ff;

   assign full     = count_ff == CNT_W'(DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = entry_ff[rd_ptr_ff];

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("push into full queue");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count did not drop on pop");

endmodule

`default_nettype wire

// ===== hdl/ufaf_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ufaf_back
   import ufaf_pkg::*;
#(
   parameter int WHITELIST_SLOTS = 3
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cfg_type       cfg,
   input  wire logic          sum_ready,
   input  wire frame_sum_type sum,
   output logic               sum_pop,
   output logic               rsp_empty,
   input  wire logic          rsp_pop,
   output logic [3:0]         rsp_verdict,
   output logic [1:0]         rsp_slot_index,
   output logic [15:0]        rsp_payload_length
);

   logic [15:0] slot_cnt_ff   [WHITELIST_SLOTS];
   logic [31:0] slot_begin_ff [WHITELIST_SLOTS];
   logic [15:0] stranger_cnt_ff;
   logic [31:0] stranger_begin_ff;

   logic        rsp_valid_ff;
   logic [3:0]  verdict_ff, verdict_in;
   logic [1:0]  slot_ff, slot_in;
   logic [15:0] length_ff;

   rate_type    unk_rate;
   rate_type    lane_rate [WHITELIST_SLOTS];
   logic [15:0] known_cnt;
   logic        checked, unknown, known;

   // take a summary when the output register is free or being drained
   assign sum_pop = sum_ready && (!rsp_valid_ff || rsp_pop);

   // rate windows and verdict
   always_comb begin
      unk_rate  = count_packet(stranger_cnt_ff, stranger_begin_ff, sum.now_ms,
                               cfg.window_len_ms);
      known_cnt = 16'h0000;
      for (int i = 0; i < WHITELIST_SLOTS; i++) begin
         lane_rate[i] = count_packet(slot_cnt_ff[i], slot_begin_ff[i], sum.now_ms,
                                     cfg.window_len_ms);
         if (sum.slot == 2'(i)) begin
            known_cnt = lane_rate[i].count;
         end
      end
      checked = !sum.size_bad && !sum.magic_bad;
      unknown = checked && sum.slot == NO_SLOT;
      known   = checked && sum.slot != NO_SLOT;
      slot_in = checked ? sum.slot : NO_SLOT;
      priority if (sum.size_bad) begin
         verdict_in = VERDICT_SIZE;
      end else if (sum.magic_bad) begin
         verdict_in = VERDICT_MAGIC;
      end else if (unknown) begin
         verdict_in = (unk_rate.count > cfg.max_unknown_per_window) ?
                      VERDICT_UNKNOWN_RATE : VERDICT_UNKNOWN_SRC;
      end else if (known_cnt > cfg.max_known_per_window) begin
         verdict_in = VERDICT_KNOWN_RATE;
      end else if (sum.payload_long) begin
         verdict_in = VERDICT_PAYLOAD_LONG;
      end else if (sum.truncated) begin
         verdict_in = VERDICT_TRUNCATED;
      end else if (sum.crc_bad) begin
         verdict_in = VERDICT_CRC;
      end else begin
         verdict_in = VERDICT_PASS;
      end
   end

   // rate counter state
   always_ff @(posedge clock) begin
      if (reset) begin
         stranger_cnt_ff   <= 16'h0000;
         stranger_begin_ff <= 32'h0000_0000;
         for (int i = 0; i < WHITELIST_SLOTS; i++) begin
            slot_cnt_ff[i]   <= 16'h0000;
            slot_begin_ff[i] <= 32'h0000_0000;
         end
      end else if (sum_pop) begin
         if (unknown) begin
            stranger_cnt_ff <= unk_rate.count;
            if (unk_rate.restart) begin
               stranger_begin_ff <= sum.now_ms;
            end
         end
         for (int i = 0; i < WHITELIST_SLOTS; i++) begin
            if (known && sum.slot == 2'(i)) begin
               slot_cnt_ff[i] <= lane_rate[i].count;
               if (lane_rate[i].restart) begin
                  slot_begin_ff[i] <= sum.now_ms;
               end
            end
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (sum_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_pop) begin
         verdict_ff <= verdict_in;
         slot_ff    <= slot_in;
         length_ff  <= sum.payload_length;
      end
   end

   assign rsp_empty          = !rsp_valid_ff;
   assign rsp_verdict        = verdict_ff;
   assign rsp_slot_index     = slot_ff;
   assign rsp_payload_length = length_ff;

   a_slot_on_early_verdict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (verdict_ff == VERDICT_SIZE || verdict_ff == VERDICT_MAGIC ||
                        verdict_ff == VERDICT_UNKNOWN_RATE ||
                        verdict_ff == VERDICT_UNKNOWN_SRC)) |-> slot_ff == NO_SLOT)
      else $error("slot reported on a verdict without a whitelist match");

   a_pop_fills_output: assert property (@(posedge clock) disable iff (reset)
      sum_pop |=> rsp_valid_ff)
      else $error("taken summary did not reach the output register");

   a_stranger_counted: assert property (@(posedge clock) disable iff (reset)
      (sum_pop && unknown) |=> stranger_cnt_ff != 16'h0000)
      else $error("unknown source packet not counted");

endmodule

`default_nettype wire

// ===== hdl/udp_frame_admission_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Datagram admission filter.
// Request side is a queue: push one datagram byte with req_push while req_full is low,
// req_first_byte / req_last_byte mark frame edges; source ip and ms time are taken
// with the last byte. One byte can be taken every cycle while req_full is low, frames may follow each other
// without gaps; req_full rises only while the two-entry summary queue is full.
// Response side is a queue: while rsp_empty is low, rsp_verdict, rsp_slot_index and
// rsp_payload_length hold the oldest verdict; rsp_pop takes it.
// A verdict reaches the response ports through the summary queue and the output register
// (the byte stage writes the summary queue directly, the rate and verdict stage then
// loads its output register); one verdict per cycle can leave while rsp_pop is high.
// A stalled receiver first fills the output register, then the summary queue, and
// only then raises req_full.
// Registers are written through csr_valid / csr_index / csr_data; csr_ready is
// always high. Reset clears frame state, the rate windows and both queues, and
// loads the register defaults; the block takes bytes from the first cycle after.
module udp_frame_admission_filter
   import ufaf_pkg::*;
#(
   parameter int WHITELIST_SLOTS   = 3,
   parameter int MAX_FRAME_BYTES   = 512,
   parameter int MAX_PAYLOAD_BYTES = 400
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_push,
   output logic               req_full,
   input  wire logic [7:0]    req_data_byte,
   input  wire logic          req_first_byte,
   input  wire logic          req_last_byte,
   input  wire logic [31:0]   req_source_ip,
   input  wire logic [31:0]   req_now_ms,
   output logic               rsp_empty,
   input  wire logic          rsp_pop,
   output logic [3:0]         rsp_verdict,
   output logic [1:0]         rsp_slot_index,
   output logic [15:0]        rsp_payload_length,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [3:0]    csr_index,
   input  wire logic [31:0]   csr_data
);

   cfg_type        cfg_ff;
   frame_sum_type  front_sum, queue_sum;
   logic           front_valid;
   logic           byte_accept;
   logic           queue_empty, queue_pop;

   assign csr_ready   = 1'b1;
   assign byte_accept = req_push && !req_full;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_word             <= 16'h0000;
         cfg_ff.whitelist_ip[0]        <= 32'd3232236554;
         cfg_ff.whitelist_ip[1]        <= 32'd3232236555;
         cfg_ff.whitelist_ip[2]        <= 32'd3232236556;
         cfg_ff.active_slots           <= 2'd3;
         cfg_ff.window_len_ms          <= 16'd1000;
         cfg_ff.max_known_per_window   <= 16'd100;
         cfg_ff.max_unknown_per_window <= 16'd10;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAGIC_WORD:     cfg_ff.magic_word             <= csr_data[15:0];
            CSR_WHITELIST_IP_A: cfg_ff.whitelist_ip[0]        <= csr_data;
            CSR_WHITELIST_IP_B: cfg_ff.whitelist_ip[1]        <= csr_data;
            CSR_WHITELIST_IP_C: cfg_ff.whitelist_ip[2]        <= csr_data;
            CSR_ACTIVE_SLOTS:   cfg_ff.active_slots           <= csr_data[1:0];
            CSR_RATE_WINDOW:    cfg_ff.window_len_ms          <= csr_data[15:0];
            CSR_MAX_KNOWN:      cfg_ff.max_known_per_window   <= csr_data[15:0];
            CSR_MAX_UNKNOWN:    cfg_ff.max_unknown_per_window <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   // byte stage: capture, crc, frame summary
   ufaf_front #(
      .WHITELIST_SLOTS   (WHITELIST_SLOTS),
      .MAX_FRAME_BYTES   (MAX_FRAME_BYTES),
      .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .byte_accept (byte_accept),
      .data_byte   (req_data_byte),
      .first_byte  (req_first_byte),
      .last_byte   (req_last_byte),
      .source_ip   (req_source_ip),
      .now_ms      (req_now_ms),
      .sum_valid   (front_valid),
      .sum         (front_sum)
   );

   // summary queue between the stages
   ufaf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_sum),
      .full      (req_full),
      .pop       (queue_pop),
      .pop_data  (queue_sum),
      .empty     (queue_empty)
   );

   // rate windows, verdict and output register
   ufaf_back #(
      .WHITELIST_SLOTS (WHITELIST_SLOTS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .sum_ready          (!queue_empty),
      .sum                (queue_sum),
      .sum_pop            (queue_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_verdict        (rsp_verdict),
      .rsp_slot_index     (rsp_slot_index),
      .rsp_payload_length (rsp_payload_length)
   );

endmodule

`default_nettype wire
